>>> sv/fenced_slot_ring_allocator_defines.svh
// Assertion helpers included by the allocator top-level source.
`ifndef FENCED_SLOT_RING_ALLOCATOR_DEFINES_SVH
`define FENCED_SLOT_RING_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define FSRA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define FSRA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/fsra_pkg.sv
package fsra_pkg;

  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned BYTES_W   = 32;
  localparam int unsigned FENCE_W   = 64;
  localparam int unsigned OFFSET_W  = 64;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned SIU_W     = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [SIU_W-1:0]   SIU_RESET = 5'd16;
  localparam logic [BYTES_W-1:0] BPS_RESET = 32'd65536;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ACQUIRE = 2'd0,
    ACT_SUBMIT  = 2'd1,
    ACT_CANCEL  = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_BUSY    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_FREE      = 2'd0,
    PH_ACQUIRED  = 2'd1,
    PH_SUBMITTED = 2'd2
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOTS_IN_USE   = 1'b0,
    CFG_BYTES_PER_SLOT = 1'b1
  } cfg_idx_t;

  // Phase update travelling from the decision logic to the phase table.
  typedef struct packed {
    logic   en;
    phase_t phase;
  } phase_wr_t;

endpackage

>>> sv/fsra_ram.sv
module fsra_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/fsra_phase_table.sv
module fsra_phase_table #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  fsra_pkg::phase_wr_t      wr,
  output fsra_pkg::phase_t         rd_phase
);

  import fsra_pkg::*;

  phase_t phase_r [DEPTH];

  // One slot is read and possibly updated per item, always at the same address.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < int'(DEPTH); i++) begin
        phase_r[i] <= PH_FREE;
      end
    end else if (wr.en) begin
      phase_r[addr] <= wr.phase;
    end
  end

  assign rd_phase = phase_r[addr];

endmodule

>>> sv/fenced_slot_ring_allocator.sv
// Slot allocator for a ring of equal-size buffer slots whose reuse is gated by
// a retire fence.
// Input channel: a command (acquire, submit or cancel) with its arguments is
// transferred at a rising edge where start is high and busy is low. busy is
// only high in the first cycle after reset; afterwards a command can be
// transferred in every cycle, so throughput is one command per clock.
// Result channel: every command yields exactly one result, shown on the out_
// ports while out_valid is high for a single cycle. A command passes the
// stage-one registers and then the result register; results leave in command
// order. The receiver cannot stall the block, so nothing is held back there.
// Configuration: cfg_we writes slots_in_use (index 0) or bytes_per_slot
// (index 1) from cfg_wdata at that edge. Write only while no command is in
// flight; changes keep all slot state.
// Reset (synchronous, active low) frees every slot, zeroes the ring pointer
// and the usage counters, and restores 16 slots of 64 KiB.
// The slot fences live in a small RAM that is read at transfer time, so the
// fence compare happens in the next cycle together with the phase lookup.
`include "fenced_slot_ring_allocator_defines.svh"

module fenced_slot_ring_allocator #(
  parameter int unsigned MAX_SLOTS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [fsra_pkg::ACTION_W-1:0]   in_action,
  input  logic [fsra_pkg::BYTES_W-1:0]    in_request_bytes,
  input  logic [fsra_pkg::FENCE_W-1:0]    in_completed_fence,
  input  logic [fsra_pkg::SLOT_W-1:0]     in_target_slot,
  input  logic [fsra_pkg::FENCE_W-1:0]    in_retire_fence,
  output logic                            out_valid,
  output logic [fsra_pkg::STATUS_W-1:0]   out_status,
  output logic [fsra_pkg::OFFSET_W-1:0]   out_slice_offset,
  output logic [fsra_pkg::BYTES_W-1:0]    out_slice_bytes,
  output logic [fsra_pkg::SLOT_W-1:0]     out_granted_slot,
  output logic [fsra_pkg::COUNT_W-1:0]    out_acquire_count,
  output logic [fsra_pkg::COUNT_W-1:0]    out_reuse_count,
  output logic [fsra_pkg::COUNT_W-1:0]    out_busy_count,
  input  logic                            cfg_we,
  input  logic [fsra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fsra_pkg::CFG_DAT_W-1:0]  cfg_wdata
);

  import fsra_pkg::*;

  localparam int unsigned IW = $clog2(MAX_SLOTS);
  // Compare width: holds the 5-bit register, MAX_SLOTS and a pointer plus one.
  localparam int unsigned LW = IW + SIU_W;
  localparam int unsigned PW = IW + BYTES_W;

  localparam logic [LW-1:0] MAX_L = LW'(MAX_SLOTS);
  localparam logic [LW-1:0] ONE_L = LW'(1);

  // Configuration registers.
  logic [SIU_W-1:0]   siu_r;
  logic [BYTES_W-1:0] bps_r;

  // Ring state and usage counters.
  logic [IW-1:0]      next_idx_r, next_idx_nxt;
  logic [COUNT_W-1:0] acq_total_r, acq_total_nxt;
  logic [COUNT_W-1:0] reuse_total_r, reuse_total_nxt;
  logic [COUNT_W-1:0] busy_total_r, busy_total_nxt;

  // Stage one: the command under decision.
  logic               s1_valid_r;
  logic [ACTION_W-1:0] s1_action_r;
  logic [BYTES_W-1:0] s1_req_r;
  logic [FENCE_W-1:0] s1_done_r;
  logic [FENCE_W-1:0] s1_fence_r;
  logic [IW-1:0]      s1_addr_r;
  logic               s1_tgt_ok_r;

  // Fence written in the same cycle the next command read the RAM.
  logic               byp_hit_r;
  logic [FENCE_W-1:0] byp_fence_r;

  // Result register.
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [OFFSET_W-1:0] out_offset_r;
  logic [BYTES_W-1:0]  out_bytes_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [COUNT_W-1:0]  out_acq_r;
  logic [COUNT_W-1:0]  out_reuse_r;
  logic [COUNT_W-1:0]  out_busy_r;

  logic busy_r;

  logic               accept;
  logic [LW-1:0]      siu_l;
  logic [LW-1:0]      count;
  logic [LW-1:0]      nidx_l;
  logic [LW-1:0]      tgt_l;
  logic               tgt_ok;
  logic [IW-1:0]      addr_sel;
  logic [IW+SLOT_W-1:0] tgt_wide;

  logic               is_acq;
  logic               is_mod;
  logic               size_ok;
  logic               grantable;
  logic               grant;
  logic               refuse;
  logic               mod_ok;
  phase_t             rd_phase;
  phase_wr_t          phase_wr;
  logic [FENCE_W-1:0] ram_fence;
  logic [FENCE_W-1:0] slot_fence;
  logic               fence_we;
  logic [LW-1:0]      addr_l;
  logic [LW-1:0]      addr_inc;
  logic [PW-1:0]      offset_prod;
  logic [IW+SLOT_W-1:0] addr_wide;
  status_t            status;

  assign accept = start && !busy_r;

  // Slot count clamped into 1..MAX_SLOTS.
  assign siu_l = LW'(siu_r);
  always_comb begin
    if (siu_r == '0) begin
      count = ONE_L;
    end else if (siu_l > MAX_L) begin
      count = MAX_L;
    end else begin
      count = siu_l;
    end
  end

  // Slot address of the incoming command. An acquire uses the pointer as the
  // command ahead of it leaves it; a pointer past a lowered count means slot 0.
  assign nidx_l   = LW'(next_idx_nxt);
  assign tgt_l    = LW'(in_target_slot);
  assign tgt_ok   = tgt_l < count;
  assign tgt_wide = {{IW{1'b0}}, in_target_slot};

  always_comb begin
    if (in_action == ACT_ACQUIRE) begin
      addr_sel = (nidx_l >= count) ? '0 : next_idx_nxt;
    end else begin
      addr_sel = tgt_ok ? tgt_wide[IW-1:0] : '0;
    end
  end

  // Decision for the command in stage one.
  assign is_acq  = s1_valid_r && (s1_action_r == ACT_ACQUIRE);
  assign is_mod  = s1_valid_r &&
                   ((s1_action_r == ACT_SUBMIT) || (s1_action_r == ACT_CANCEL));
  assign size_ok = (s1_req_r != '0) && (s1_req_r <= bps_r);

  assign slot_fence = byp_hit_r ? byp_fence_r : ram_fence;

  always_comb begin
    case (rd_phase)
      PH_FREE:      grantable = 1'b1;
      PH_SUBMITTED: grantable = slot_fence <= s1_done_r;
      default:      grantable = 1'b0;
    endcase
  end

  assign grant    = is_acq && size_ok && grantable;
  assign refuse   = is_acq && size_ok && !grantable;
  assign mod_ok   = is_mod && s1_tgt_ok_r && (rd_phase == PH_ACQUIRED);
  assign fence_we = mod_ok && (s1_action_r == ACT_SUBMIT);

  always_comb begin
    phase_wr.en = grant || mod_ok;
    if (grant) begin
      phase_wr.phase = PH_ACQUIRED;
    end else if (s1_action_r == ACT_SUBMIT) begin
      phase_wr.phase = PH_SUBMITTED;
    end else begin
      phase_wr.phase = PH_FREE;
    end
  end

  // Pointer advance with wrap at the slot count.
  assign addr_l   = LW'(s1_addr_r);
  assign addr_inc = addr_l + ONE_L;
  always_comb begin
    next_idx_nxt = next_idx_r;
    if (grant) begin
      next_idx_nxt = (addr_inc >= count) ? '0 : addr_inc[IW-1:0];
    end
  end

  assign acq_total_nxt   = acq_total_r + COUNT_W'(grant);
  assign reuse_total_nxt = reuse_total_r + COUNT_W'(grant && (rd_phase == PH_SUBMITTED));
  assign busy_total_nxt  = busy_total_r + COUNT_W'(refuse);

  always_comb begin
    status = ST_INVALID;
    unique case (s1_action_r)
      ACT_ACQUIRE: begin
        if (size_ok) begin
          status = grant ? ST_OK : ST_BUSY;
        end
      end
      ACT_SUBMIT, ACT_CANCEL: begin
        if (mod_ok) begin
          status = ST_OK;
        end
      end
      default: status = ST_INVALID;
    endcase
  end

  assign offset_prod = PW'(s1_addr_r) * PW'(bps_r);
  assign addr_wide   = {{SLOT_W{1'b0}}, s1_addr_r};

  fsra_phase_table #(
    .DEPTH (MAX_SLOTS)
  ) u_phase (
    .clk      (clk),
    .rst_n    (rst_n),
    .addr     (s1_addr_r),
    .wr       (phase_wr),
    .rd_phase (rd_phase)
  );

  // Fences need no clearing: a fence is only looked at for a submitted slot,
  // and submit always writes it.
  fsra_ram #(
    .WIDTH (FENCE_W),
    .DEPTH (MAX_SLOTS)
  ) u_fence (
    .clk   (clk),
    .we    (fence_we),
    .waddr (s1_addr_r),
    .wdata (s1_fence_r),
    .re    (accept),
    .raddr (addr_sel),
    .rdata (ram_fence)
  );

  // Configuration and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      siu_r         <= SIU_RESET;
      bps_r         <= BPS_RESET;
      next_idx_r    <= '0;
      acq_total_r   <= '0;
      reuse_total_r <= '0;
      busy_total_r  <= '0;
      s1_valid_r    <= 1'b0;
      byp_hit_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      busy_r        <= 1'b1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_SLOTS_IN_USE:   siu_r <= cfg_wdata[SIU_W-1:0];
          CFG_BYTES_PER_SLOT: bps_r <= cfg_wdata[BYTES_W-1:0];
          default:            ;
        endcase
      end
      next_idx_r    <= next_idx_nxt;
      acq_total_r   <= acq_total_nxt;
      reuse_total_r <= reuse_total_nxt;
      busy_total_r  <= busy_total_nxt;
      s1_valid_r    <= accept;
      byp_hit_r     <= accept && fence_we && (addr_sel == s1_addr_r);
      out_valid_r   <= s1_valid_r;
      busy_r        <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action_r <= in_action;
      s1_req_r    <= in_request_bytes;
      s1_done_r   <= in_completed_fence;
      s1_fence_r  <= in_retire_fence;
      s1_addr_r   <= addr_sel;
      s1_tgt_ok_r <= tgt_ok;
    end
    byp_fence_r <= s1_fence_r;
    if (s1_valid_r) begin
      out_status_r <= status;
      out_offset_r <= grant ? OFFSET_W'(offset_prod) : '0;
      out_bytes_r  <= grant ? s1_req_r : '0;
      out_slot_r   <= grant ? addr_wide[SLOT_W-1:0] : '0;
      out_acq_r    <= acq_total_nxt;
      out_reuse_r  <= reuse_total_nxt;
      out_busy_r   <= busy_total_nxt;
    end
  end

  assign busy              = busy_r;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slice_offset  = out_offset_r;
  assign out_slice_bytes   = out_bytes_r;
  assign out_granted_slot  = out_slot_r;
  assign out_acquire_count = out_acq_r;
  assign out_reuse_count   = out_reuse_r;
  assign out_busy_count    = out_busy_r;

  `FSRA_ASSERT_NXT(a_result_follows_command, clk, rst_n, s1_valid_r, out_valid_r,
                   "decided command produced no result strobe")

  `FSRA_ASSERT_IMP(a_grant_on_open_slot, clk, rst_n, grant,
                   (rd_phase != PH_ACQUIRED) && (addr_l < count),
                   "acquire granted an occupied or out-of-range slot")

  `FSRA_ASSERT_NXT(a_busy_count_held, clk, rst_n, !refuse,
                   busy_total_r == $past(busy_total_r),
                   "busy counter moved without a refused acquire")

  `FSRA_ASSERT_IMP(a_fence_only_on_submit, clk, rst_n, fence_we,
                   phase_wr.en && (phase_wr.phase == PH_SUBMITTED),
                   "fence written without a submit phase update")

endmodule

>>> verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fsra_pkg::*;

  // Ring depth the block is built with, and the one action code that the
  // package leaves unnamed because the block must reject it.
  localparam int unsigned RING_DEPTH = 16;
  localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;
  localparam logic [FENCE_W-1:0] FENCE_MAX = '1;

  // Settling allowed once every answer is in, before any register write and
  // before the verdict.
  localparam int unsigned SETTLE_CYCLES = 6;
  // Watchdog limit, set well above the length of a correct run.
  localparam int unsigned RUN_LIMIT = 100000;
  localparam int unsigned ITEMS_PER_SETUP = 154;

  // One command as the sender presents it. The action stays a raw two-bit
  // value so that the unknown code can be sent as well.
  typedef struct {
    logic [ACTION_W-1:0] action;
    logic [BYTES_W-1:0]  req_bytes;
    logic [FENCE_W-1:0]  done_fence;
    logic [SLOT_W-1:0]   target;
    logic [FENCE_W-1:0]  retire_fence;
  } alloc_cmd_t;

  typedef struct {
    status_t              status;
    logic [OFFSET_W-1:0]  offset;
    logic [BYTES_W-1:0]   granted_bytes;
    logic [SLOT_W-1:0]    slot;
    logic [COUNT_W-1:0]   acquired;
    logic [COUNT_W-1:0]   reclaimed;
    logic [COUNT_W-1:0]   refused;
  } alloc_result_t;

  // A row of the directed script is either a ring setup (both registers) or
  // a command, optionally with its answer written out by hand.
  typedef struct {
    bit                 is_setup;
    logic [SIU_W-1:0]   slots;
    logic [BYTES_W-1:0] bytes;
    alloc_cmd_t         cmd;
    bit                 hand_checked;
    alloc_result_t      want;
  } script_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [ACTION_W-1:0]    in_action;
  logic [BYTES_W-1:0]     in_request_bytes;
  logic [FENCE_W-1:0]     in_completed_fence;
  logic [SLOT_W-1:0]      in_target_slot;
  logic [FENCE_W-1:0]     in_retire_fence;
  logic                   out_valid;
  logic [STATUS_W-1:0]    out_status;
  logic [OFFSET_W-1:0]    out_slice_offset;
  logic [BYTES_W-1:0]     out_slice_bytes;
  logic [SLOT_W-1:0]      out_granted_slot;
  logic [COUNT_W-1:0]     out_acquire_count;
  logic [COUNT_W-1:0]     out_reuse_count;
  logic [COUNT_W-1:0]     out_busy_count;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DAT_W-1:0]   cfg_wdata;

  fenced_slot_ring_allocator #(
    .MAX_SLOTS(RING_DEPTH)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_action          (in_action),
    .in_request_bytes   (in_request_bytes),
    .in_completed_fence (in_completed_fence),
    .in_target_slot     (in_target_slot),
    .in_retire_fence    (in_retire_fence),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_slice_offset   (out_slice_offset),
    .out_slice_bytes    (out_slice_bytes),
    .out_granted_slot   (out_granted_slot),
    .out_acquire_count  (out_acquire_count),
    .out_reuse_count    (out_reuse_count),
    .out_busy_count     (out_busy_count),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // Shadow copy of the allocator: slot table, ring pointer, usage counters
  // and the two registers as last written.
  phase_t              slot_state [RING_DEPTH];
  logic [FENCE_W-1:0]  slot_retire [RING_DEPTH];
  int unsigned         ring_ptr;
  logic [COUNT_W-1:0]  grant_total;
  logic [COUNT_W-1:0]  reclaim_total;
  logic [COUNT_W-1:0]  refuse_total;
  logic [SIU_W-1:0]    ring_slots;
  logic [BYTES_W-1:0]  slot_bytes;

  // Answers still owed by the block, oldest first.
  alloc_result_t       owed_results [$];
  script_row_t         directed_script [$];

  // Stand-in for the consumer's progress: acquires report it as completed,
  // submits ask for a little beyond it, so submitted slots retire over time.
  logic [FENCE_W-1:0]  fence_clock;

  int unsigned         cycle_count = 0;
  int unsigned         mismatch_count = 0;
  int unsigned         sent_count = 0;
  int unsigned         setup_count = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Effective ring size: zero counts as one, anything past the built depth
  // is clamped to it.
  function automatic int unsigned ring_span();
    if (ring_slots == '0) return 1;
    if (ring_slots > RING_DEPTH) return RING_DEPTH;
    return ring_slots;
  endfunction

  // Applies one accepted command to the shadow state and returns the answer
  // the block has to give for it.
  function automatic alloc_result_t predict_alloc(alloc_cmd_t c);
    alloc_result_t r;
    int unsigned   span;
    int unsigned   idx;
    r.status = ST_INVALID;
    r.offset = '0;
    r.granted_bytes = '0;
    r.slot = '0;
    span = ring_span();
    case (c.action)
      ACT_ACQUIRE: begin
        if (c.req_bytes != '0 && c.req_bytes <= slot_bytes) begin
          // A pointer left past a lowered ring size falls back to slot zero.
          idx = (ring_ptr >= span) ? 0 : ring_ptr;
          if (slot_state[idx] == PH_ACQUIRED ||
              (slot_state[idx] == PH_SUBMITTED && slot_retire[idx] > c.done_fence)) begin
            refuse_total = refuse_total + 1'b1;
            r.status = ST_BUSY;
          end else begin
            if (slot_state[idx] == PH_SUBMITTED) reclaim_total = reclaim_total + 1'b1;
            slot_state[idx] = PH_ACQUIRED;
            slot_retire[idx] = '0;
            r.offset = OFFSET_W'(idx) * OFFSET_W'(slot_bytes);
            r.granted_bytes = c.req_bytes;
            r.slot = SLOT_W'(idx);
            ring_ptr = (idx + 1 >= span) ? 0 : idx + 1;
            grant_total = grant_total + 1'b1;
            r.status = ST_OK;
          end
        end
      end
      ACT_SUBMIT, ACT_CANCEL: begin
        if (c.target < span && slot_state[c.target] == PH_ACQUIRED) begin
          if (c.action == ACT_SUBMIT) begin
            slot_state[c.target] = PH_SUBMITTED;
            slot_retire[c.target] = c.retire_fence;
          end else begin
            slot_state[c.target] = PH_FREE;
            slot_retire[c.target] = '0;
          end
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    r.acquired = grant_total;
    r.reclaimed = reclaim_total;
    r.refused = refuse_total;
    return r;
  endfunction

  function automatic alloc_result_t outcome(status_t st, logic [OFFSET_W-1:0] off,
                                            logic [BYTES_W-1:0] sz, logic [SLOT_W-1:0] slot,
                                            logic [COUNT_W-1:0] acq_n,
                                            logic [COUNT_W-1:0] reuse_n,
                                            logic [COUNT_W-1:0] busy_n);
    alloc_result_t r;
    r.status = st;
    r.offset = off;
    r.granted_bytes = sz;
    r.slot = slot;
    r.acquired = acq_n;
    r.reclaimed = reuse_n;
    r.refused = busy_n;
    return r;
  endfunction

  task automatic add_cmd(logic [ACTION_W-1:0] act, logic [BYTES_W-1:0] req,
                         logic [FENCE_W-1:0] done, logic [SLOT_W-1:0] tgt,
                         logic [FENCE_W-1:0] fence, bit checked, alloc_result_t want);
    script_row_t row;
    row.is_setup = 1'b0;
    row.slots = '0;
    row.bytes = '0;
    row.cmd.action = act;
    row.cmd.req_bytes = req;
    row.cmd.done_fence = done;
    row.cmd.target = tgt;
    row.cmd.retire_fence = fence;
    row.hand_checked = checked;
    row.want = want;
    directed_script.push_back(row);
  endtask

  task automatic add_setup(logic [SIU_W-1:0] slots, logic [BYTES_W-1:0] bytes);
    script_row_t row;
    row.is_setup = 1'b1;
    row.slots = slots;
    row.bytes = bytes;
    row.cmd = '{default: '0};
    row.hand_checked = 1'b0;
    row.want = outcome(ST_INVALID, '0, '0, '0, '0, '0, '0);
    directed_script.push_back(row);
  endtask

  // Directed script. Rows with a hand-written answer cover reset behavior,
  // the size limits and the rejection codes; the rest go through the shadow.
  task automatic build_script();
    alloc_result_t none;
    none = outcome(ST_INVALID, '0, '0, '0, '0, '0, '0);
    // Zero size, one past the slot size and the largest size are all refused.
    add_cmd(ACT_ACQUIRE, 32'd0, '0, '0, '0, 1'b1, none);
    add_cmd(ACT_ACQUIRE, 32'd65537, '0, '0, '0, 1'b1, none);
    add_cmd(ACT_ACQUIRE, '1, FENCE_MAX, '1, FENCE_MAX, 1'b1, none);
    // A full slot and then a one-byte grant from the next slot.
    add_cmd(ACT_ACQUIRE, 32'd65536, '0, '0, '0, 1'b1,
            outcome(ST_OK, '0, 32'd65536, 4'd0, 32'd1, '0, '0));
    add_cmd(ACT_ACQUIRE, 32'd1, FENCE_MAX, '1, FENCE_MAX, 1'b1,
            outcome(ST_OK, 64'd65536, 32'd1, 4'd1, 32'd2, '0, '0));
    // Slot 0 is handed to the consumer with the highest fence; slot 1 comes back.
    add_cmd(ACT_SUBMIT, '1, FENCE_MAX, 4'd0, FENCE_MAX, 1'b1,
            outcome(ST_OK, '0, '0, '0, 32'd2, '0, '0));
    add_cmd(ACT_CANCEL, '0, '0, 4'd1, '0, 1'b1,
            outcome(ST_OK, '0, '0, '0, 32'd2, '0, '0));
    // Submit or cancel of a slot that is not held, and the unknown action.
    add_cmd(ACT_SUBMIT, '0, '0, 4'd1, 64'd9, 1'b1,
            outcome(ST_INVALID, '0, '0, '0, 32'd2, '0, '0));
    add_cmd(ACT_CANCEL, '0, '0, 4'd15, '0, 1'b1,
            outcome(ST_INVALID, '0, '0, '0, 32'd2, '0, '0));
    add_cmd(ACT_UNKNOWN, '1, FENCE_MAX, '1, FENCE_MAX, 1'b1,
            outcome(ST_INVALID, '0, '0, '0, 32'd2, '0, '0));
    // Shrinking the ring leaves the pointer at 2, so acquires fall back to
    // slot 0, whose fence has not retired yet and then has.
    add_setup(5'd2, 32'd65536);
    add_cmd(ACT_ACQUIRE, 32'd100, FENCE_MAX - 1, '0, '0, 1'b1,
            outcome(ST_BUSY, '0, '0, '0, 32'd2, '0, 32'd1));
    add_cmd(ACT_ACQUIRE, 32'd100, FENCE_MAX, '0, '0, 1'b1,
            outcome(ST_OK, '0, 32'd100, 4'd0, 32'd3, 32'd1, 32'd1));
    add_cmd(ACT_ACQUIRE, 32'd65536, '0, '0, '0, 1'b0, none);
    add_cmd(ACT_ACQUIRE, 32'd5, '0, '0, '0, 1'b0, none);
    add_cmd(ACT_SUBMIT, '0, '0, 4'd2, 64'd1, 1'b1,
            outcome(ST_INVALID, '0, '0, '0, 32'd4, 32'd1, 32'd2));
    add_cmd(ACT_SUBMIT, '0, '0, 4'd1, 64'd5, 1'b0, none);
    // A ring size of zero means one slot: slot 1 is now out of reach.
    add_setup(5'd0, '1);
    add_cmd(ACT_CANCEL, '0, '0, 4'd1, '0, 1'b0, none);
    add_cmd(ACT_CANCEL, '0, '0, 4'd0, '0, 1'b0, none);
    add_cmd(ACT_ACQUIRE, '1, '0, '0, '0, 1'b0, none);
    // Oversized ring count is clamped; a slot size of zero refuses everything.
    add_setup(5'd31, '0);
    add_cmd(ACT_ACQUIRE, 32'd1, '0, '0, '0, 1'b0, none);
    // Full ring with the largest slots: reclaim slot 0, then slot 1 once its
    // fence has been reached.
    add_setup(5'd16, '1);
    add_cmd(ACT_SUBMIT, '0, '0, 4'd0, 64'd3, 1'b0, none);
    add_cmd(ACT_ACQUIRE, 32'd7, 64'd3, '0, '0, 1'b0, none);
    add_cmd(ACT_ACQUIRE, 32'd7, 64'd4, '0, '0, 1'b0, none);
    add_cmd(ACT_ACQUIRE, 32'h8000_0000, 64'd5, '0, '0, 1'b0, none);
  endtask

  // Presents one command and holds it until the block takes it. The answer
  // is predicted at the transfer edge, so the shadow never runs ahead.
  // After the transfer each following cycle is left idle with the given chance.
  task automatic send_cmd(alloc_cmd_t c, bit checked, alloc_result_t want,
                          int unsigned idle_pct);
    alloc_result_t calc;
    start <= 1'b1;
    in_action <= c.action;
    in_request_bytes <= c.req_bytes;
    in_completed_fence <= c.done_fence;
    in_target_slot <= c.target;
    in_retire_fence <= c.retire_fence;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    calc = predict_alloc(c);
    if (checked) owed_results.push_back(want);
    else owed_results.push_back(calc);
    sent_count++;
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stops sending and waits until every owed answer has been seen.
  task automatic drain();
    start <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers while the block is quiet. The upper bits of the
  // ring-size write carry junk, which the block must ignore.
  task automatic apply_setup(logic [SIU_W-1:0] slots, logic [BYTES_W-1:0] bytes);
    logic [CFG_DAT_W-1:0] junk;
    junk = $urandom;
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_SLOTS_IN_USE;
    cfg_wdata <= {junk[CFG_DAT_W-1:SIU_W], slots};
    @(posedge clk);
    cfg_index <= CFG_BYTES_PER_SLOT;
    cfg_wdata <= bytes;
    @(posedge clk);
    cfg_we <= 1'b0;
    ring_slots = slots;
    slot_bytes = bytes;
    setup_count++;
  endtask

  // Random command. Most commands follow the normal life of a slot (acquire
  // with the consumer's progress, submit or cancel a slot actually held);
  // the rest carry out-of-range sizes, wrong targets or wild fences.
  task automatic make_random_cmd(output alloc_cmd_t c);
    int unsigned pick;
    int unsigned roll;
    int unsigned held [$];
    pick = $urandom_range(99, 0);
    c.req_bytes = $urandom;
    c.done_fence = {$urandom, $urandom};
    c.target = SLOT_W'($urandom);
    c.retire_fence = {$urandom, $urandom};
    if (pick < 48) c.action = ACT_ACQUIRE;
    else if (pick < 78) c.action = ACT_SUBMIT;
    else if (pick < 95) c.action = ACT_CANCEL;
    else c.action = ACT_UNKNOWN;
    if (c.action == ACT_ACQUIRE) begin
      roll = $urandom_range(99, 0);
      if (roll < 70) c.req_bytes = (slot_bytes == '0) ? '0 : $urandom_range(slot_bytes, 1);
      else if (roll < 78) c.req_bytes = slot_bytes;
      else if (roll < 83) c.req_bytes = 32'd1;
      else if (roll < 88) c.req_bytes = slot_bytes + 1'b1;
      else if (roll < 92) c.req_bytes = '0;
      if ($urandom_range(9, 0) != 0) c.done_fence = fence_clock;
      fence_clock = fence_clock + $urandom_range(2, 0);
    end else if (c.action != ACT_UNKNOWN) begin
      for (int i = 0; i < RING_DEPTH; i++)
        if (slot_state[i] == PH_ACQUIRED) held.push_back(i);
      if (held.size() != 0 && $urandom_range(9, 0) < 8)
        c.target = SLOT_W'(held[$urandom_range(held.size() - 1, 0)]);
      if (c.action == ACT_SUBMIT && $urandom_range(9, 0) != 0)
        c.retire_fence = fence_clock + $urandom_range(6, 0);
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Every strobed result is a transfer the block cannot repeat, so it is
  // compared at the edge that closes its cycle against the oldest answer owed.
  always @(posedge clk) begin : result_check
    alloc_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (owed_results.size() == 0) begin
        $error("result transfer with no command outstanding");
        mismatch_count++;
      end else begin
        want = owed_results.pop_front();
        check_field("status", 64'(want.status), 64'(out_status));
        check_field("slice_offset", want.offset, out_slice_offset);
        check_field("slice_bytes", 64'(want.granted_bytes), 64'(out_slice_bytes));
        check_field("granted_slot", 64'(want.slot), 64'(out_granted_slot));
        check_field("acquire_count", 64'(want.acquired), 64'(out_acquire_count));
        check_field("reuse_count", 64'(want.reclaimed), 64'(out_reuse_count));
        check_field("busy_count", 64'(want.refused), 64'(out_busy_count));
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("[fenced_slot_ring_allocator] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    alloc_cmd_t    c;
    alloc_result_t unused;
    int unsigned   idle_pct;
    int unsigned   seg;
    logic [SIU_W-1:0]   slots;
    logic [BYTES_W-1:0] bytes;

    unused = outcome(ST_OK, '0, '0, '0, '0, '0, '0);
    rst_n <= 1'b0;
    start <= 1'b0;
    in_action <= ACT_ACQUIRE;
    in_request_bytes <= '0;
    in_completed_fence <= '0;
    in_target_slot <= '0;
    in_retire_fence <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_SLOTS_IN_USE;
    cfg_wdata <= '0;

    // Shadow starts from the reset state of the block.
    for (int i = 0; i < RING_DEPTH; i++) begin
      slot_state[i] = PH_FREE;
      slot_retire[i] = '0;
    end
    ring_ptr = 0;
    grant_total = '0;
    reclaim_total = '0;
    refuse_total = '0;
    ring_slots = SIU_RESET;
    slot_bytes = BPS_RESET;
    fence_clock = '0;
    build_script();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: commands go back to back, pausing only to drain before a setup.
    foreach (directed_script[i]) begin
      if (directed_script[i].is_setup)
        apply_setup(directed_script[i].slots, directed_script[i].bytes);
      else
        send_cmd(directed_script[i].cmd, directed_script[i].hand_checked,
                 directed_script[i].want, 0);
    end

    // Random part: three pacing phases (sender idle chance of 28 and then 51
    // percent, then none), each split over four ring setups.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 28 : (phase == 1) ? 51 : 0;
      for (int part = 0; part < 4; part++) begin
        seg = phase * 4 + part;
        case (seg % 6)
          0: begin slots = 5'd16; bytes = 32'd65536; end
          1: begin slots = 5'd1;  bytes = 32'd1; end
          2: begin slots = 5'd4;  bytes = '1; end
          3: begin slots = 5'd0;  bytes = $urandom; end
          4: begin slots = 5'd31; bytes = $urandom_range(4096, 1); end
          default: begin
            slots = SIU_W'($urandom_range(31, 0));
            bytes = $urandom_range(100000, 1);
          end
        endcase
        apply_setup(slots, bytes);
        // Start the consumer's progress at zero, anywhere, or just short of
        // the top so that fences wrap around during the segment.
        case ($urandom_range(2, 0))
          0: fence_clock = '0;
          1: fence_clock = {$urandom, $urandom};
          default: fence_clock = FENCE_MAX - 64'd40;
        endcase
        repeat (ITEMS_PER_SETUP) begin
          make_random_cmd(c);
          send_cmd(c, 1'b0, unused, idle_pct);
        end
      end
    end

    drain();
    $display("Run covered %0d commands over %0d ring setups in three sender pacing phases.",
             sent_count, setup_count);
    $display("Shadow ring counted %0d grants, %0d fenced reclaims and %0d busy refusals.",
             grant_total, reclaim_total, refuse_total);
    if (mismatch_count == 0) begin
      $display("[fenced_slot_ring_allocator] OK");
    end else begin
      $display("[fenced_slot_ring_allocator] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/fsra_pkg.sv
sv/fsra_ram.sv
sv/fsra_phase_table.sv
sv/fenced_slot_ring_allocator.sv
verif/tb_top.sv
